[sv/bmcr_pkg.sv]
// Package for the cartridge bank mapper with clock registers.
// Holds access kinds, control regions, clock-register select codes and field widths.
// No dependencies.
`timescale 1ns / 1ps

package bmcr_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned AddrW   = 15;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RomBankW = 7;
  localparam int unsigned RamBankW = 2;
  localparam int unsigned SelW    = 3;
  localparam int unsigned SecW    = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned DayW    = 16;

  localparam int unsigned InDataW  = 24;  // address + write_value, padded to bytes
  localparam int unsigned OutDataW = 24;  // read_data + banks + enable, padded

  // Bus access kinds
  localparam logic [KindW-1:0] KIND_CTRL   = 2'd0;
  localparam logic [KindW-1:0] KIND_RD     = 2'd1;
  localparam logic [KindW-1:0] KIND_WR     = 2'd2;
  localparam logic [KindW-1:0] KIND_UNUSED = 2'd3;

  // Control write regions, address bits 14:13
  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_ROMBANK = 2'd1;
  localparam logic [1:0] REG_SELECT  = 2'd2;
  localparam logic [1:0] REG_LATCH   = 2'd3;

  // Clock register select
  localparam logic [SelW-1:0] SEL_NONE  = 3'd0;
  localparam logic [SelW-1:0] SEL_SEC   = 3'd1;
  localparam logic [SelW-1:0] SEL_MIN   = 3'd2;
  localparam logic [SelW-1:0] SEL_HOUR  = 3'd3;
  localparam logic [SelW-1:0] SEL_DAYLO = 3'd4;
  localparam logic [SelW-1:0] SEL_DAYHI = 3'd5;

  localparam logic [ByteW-1:0] ENABLE_NIBBLE = 8'h0A;
  localparam logic [ByteW-1:0] CLK_SEL_LO    = 8'h08;
  localparam logic [ByteW-1:0] CLK_SEL_HI    = 8'h0C;
  localparam logic [ByteW-1:0] DAYHI_MASK    = 8'hC1;
  localparam logic [ByteW-1:0] DAYHI_FILL    = 8'h3E;

  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [SecW-1:0]  min;
    logic [HourW-1:0] hour;
    logic [DayW-1:0]  day;
  } clk_regs_t;

  // Byte modulo 60 by binary subtraction of 240, 120, 60
  function automatic logic [SecW-1:0] mod60(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    r = v;
    if (r >= 8'd240) r = r - 8'd240;
    if (r >= 8'd120) r = r - 8'd120;
    if (r >= 8'd60)  r = r - 8'd60;
    return r[SecW-1:0];
  endfunction

  // Byte modulo 24 by binary subtraction of 192, 96, 48, 24
  function automatic logic [HourW-1:0] mod24(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    r = v;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    return r[HourW-1:0];
  endfunction

endpackage

[sv/bank_mapper_with_clock_registers_top.sv]
// Top level of the cartridge bank mapper with clock registers.
// Depends on bmcr_pkg for codes, widths and the modulo helpers.
`timescale 1ns / 1ps

// Usage
//   Slave channel: one word per bus access. tuser carries the access kind
//   (control write, external RAM read, external RAM write); tdata carries
//   the address and the byte written.
//   Master channel: one word per accepted access, in order. tdata carries
//   the clock byte read (else zero) and the bank and enable state as they
//   stand after the access; tuser is high when the RAM access belongs to
//   the external RAM store rather than to a clock register.
// Timing
//   The access is held in an input register, then decoded, applied to the
//   mapper state and captured in the result register in one pass.
//   Throughput is one word per cycle while the receiver holds tready high.
// Reset
//   Clears both registers' valid flags; ROM bank returns to 1, RAM bank,
//   enable, clock select, latch and all clock registers to 0, and the
//   remembered latch byte to 0xFF.
// Stall
//   While the receiver holds tready low the result word holds, the input
//   register fills, and then the slave tready drops; nothing is dropped.
module bank_mapper_with_clock_registers_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [14:0] address, [22:15] write_value, [23] zero
  input  logic [bmcr_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [1:0] kind
  input  logic [bmcr_pkg::KindW-1:0]    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] read_data, [9:8] ram_bank, [16:10] rom_bank, [17] ram_enabled, [23:18] zero
  output logic [bmcr_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] forward_to_ram
  output logic                          m_axis_tuser_o
);
  import bmcr_pkg::*;

  // Input register
  logic                 in_vld_q;
  logic [KindW-1:0]     in_kind_q;
  logic [AddrW-1:0]     in_addr_q;
  logic [ByteW-1:0]     in_val_q;

  // Result register
  logic                 out_vld_q;
  logic [OutDataW-1:0]  out_data_q, out_data_d;
  logic                 out_fwd_q, out_fwd_d;

  // Mapper state
  logic                 ram_en_q, ram_en_d;
  logic [RomBankW-1:0]  rom_bank_q, rom_bank_d;
  logic [RamBankW-1:0]  ram_bank_q, ram_bank_d;
  logic [SelW-1:0]      clk_sel_q, clk_sel_d;
  logic [ByteW-1:0]     prev_latch_q, prev_latch_d;
  logic                 latched_q, latched_d;
  clk_regs_t            live_q, live_d;
  clk_regs_t            held_q, held_d;

  logic                 advance;
  logic                 fire;
  logic                 s_fire;
  logic [1:0]           region;
  logic [ByteW-1:0]     rd_byte;
  clk_regs_t            cur, cur_w;
  logic [RomBankW-1:0]  rom_raw;

  // Result slot frees when empty or taken this cycle
  assign advance = !out_vld_q || m_axis_tready_i;
  assign fire    = in_vld_q && advance;
  assign s_axis_tready_o = !in_vld_q || advance;
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign region  = in_addr_q[AddrW-1 -: 2];
  assign rom_raw = in_val_q[RomBankW-1:0];

  // Decode the held access and work out the state after it
  always_comb begin
    ram_en_d     = ram_en_q;
    rom_bank_d   = rom_bank_q;
    ram_bank_d   = ram_bank_q;
    clk_sel_d    = clk_sel_q;
    prev_latch_d = prev_latch_q;
    latched_d    = latched_q;
    live_d       = live_q;
    held_d       = held_q;
    rd_byte      = '0;
    out_fwd_d    = 1'b0;
    cur          = latched_q ? held_q : live_q;
    cur_w        = cur;

    case (clk_sel_q)
      SEL_SEC:   cur_w.sec  = mod60(in_val_q);
      SEL_MIN:   cur_w.min  = mod60(in_val_q);
      SEL_HOUR:  cur_w.hour = mod24(in_val_q);
      SEL_DAYLO: cur_w.day  = {cur.day[DayW-1 -: ByteW], in_val_q};
      default:   cur_w.day  = {(in_val_q & DAYHI_MASK) | DAYHI_FILL, cur.day[ByteW-1:0]};
    endcase

    case (in_kind_q)
      KIND_CTRL: begin
        case (region)
          REG_ENABLE: begin
            if (in_val_q[3:0] == ENABLE_NIBBLE[3:0]) ram_en_d = 1'b1;
            else if (in_val_q == '0) ram_en_d = 1'b0;
          end
          REG_ROMBANK: begin
            rom_bank_d = (rom_raw == '0) ? RomBankW'(1) : rom_raw;
          end
          REG_SELECT: begin
            if (ram_en_q) begin
              if (in_val_q inside {[CLK_SEL_LO:CLK_SEL_HI]}) begin
                clk_sel_d = SelW'(in_val_q - (CLK_SEL_LO - 8'd1));
              end else begin
                clk_sel_d  = SEL_NONE;
                ram_bank_d = in_val_q[RamBankW-1:0];
              end
            end
          end
          default: begin
            // Latch on a 0-then-1 pair: copy live clock, toggle latched view
            if (prev_latch_q == '0 && in_val_q == 8'd1) begin
              held_d    = live_q;
              latched_d = !latched_q;
            end
            prev_latch_d = in_val_q;
          end
        endcase
      end
      KIND_RD: begin
        if (clk_sel_q == SEL_NONE) begin
          out_fwd_d = 1'b1;
        end else begin
          case (clk_sel_q)
            SEL_SEC:   rd_byte = ByteW'(cur.sec);
            SEL_MIN:   rd_byte = ByteW'(cur.min);
            SEL_HOUR:  rd_byte = ByteW'(cur.hour);
            SEL_DAYLO: rd_byte = cur.day[ByteW-1:0];
            default:   rd_byte = cur.day[DayW-1 -: ByteW];
          endcase
        end
      end
      KIND_WR: begin
        if (clk_sel_q == SEL_NONE) begin
          out_fwd_d = 1'b1;
        end else if (latched_q) begin
          held_d = cur_w;
        end else begin
          live_d = cur_w;
        end
      end
      default: begin
        // Unused kind: no state change
      end
    endcase

    out_data_d = {6'd0, ram_en_d, rom_bank_d, ram_bank_d, rd_byte};
  end

  // Input register: load on slave handshake, drain into the result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_kind_q <= s_axis_tuser_i;
      in_addr_q <= s_axis_tdata_i[AddrW-1:0];
      in_val_q  <= s_axis_tdata_i[AddrW +: ByteW];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
      out_fwd_q  <= out_fwd_d;
    end
  end

  // Mapper state: commit when the access moves into the result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q     <= 1'b0;
      rom_bank_q   <= RomBankW'(1);
      ram_bank_q   <= '0;
      clk_sel_q    <= SEL_NONE;
      prev_latch_q <= 8'hFF;
      latched_q    <= 1'b0;
      live_q       <= '0;
      held_q       <= '0;
    end else if (fire) begin
      ram_en_q     <= ram_en_d;
      rom_bank_q   <= rom_bank_d;
      ram_bank_q   <= ram_bank_d;
      clk_sel_q    <= clk_sel_d;
      prev_latch_q <= prev_latch_d;
      latched_q    <= latched_d;
      live_q       <= live_d;
      held_q       <= held_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_fwd_q;

`ifndef SYNTH
  // ROM bank zero is never selectable
  a_rom_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_bank_q != '0)
    else $error("ROM bank register holds zero");

  // Clock select stays within the clock registers (seconds to day high) or none
  a_clk_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clk_sel_q <= SEL_DAYHI)
    else $error("clock select out of range");

  // A forwarded access never carries clock data
  a_fwd_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_fwd_q |-> out_data_q[ByteW-1:0] == '0)
    else $error("forwarded access with nonzero read data");

  // The latched view only flips on a latch-region control write
  a_latch_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && in_kind_q == KIND_CTRL && region == REG_LATCH) |=> $stable(latched_q))
    else $error("latch flag changed without a latch write");

  // Live clock never changes while the latched copy is in view
  a_live_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q |=> $stable(live_q))
    else $error("live clock changed while latched");
`endif

endmodule

[bench/bmcr_access_checker.sv]
// Result checker for the cartridge bank mapper with clock registers.
// Predicts each result word from the accepted bus accesses and compares it in order.
// Depends on bmcr_pkg for access kinds, control regions, select codes and widths.
`timescale 1ns / 1ps

module bmcr_access_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [bmcr_pkg::InDataW-1:0]  s_tdata_i,
  input  logic [bmcr_pkg::KindW-1:0]    s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [bmcr_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                          m_tuser_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   clock_hits_o
);

  import bmcr_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0]    read_byte;
    logic                to_ram;
    logic [RamBankW-1:0] ram_bank;
    logic [RomBankW-1:0] rom_bank;
    logic                enabled;
  } access_result_t;

  // Mapper state as the block should hold it
  logic                enabled_q;
  logic [RomBankW-1:0] rom_bank_q;
  logic [RamBankW-1:0] ram_bank_q;
  logic [SelW-1:0]     clock_sel_q;
  logic [ByteW-1:0]    last_latch_byte_q;
  logic                latched_q;
  clk_regs_t           live_clk;
  clk_regs_t           held_clk;

  access_result_t mapper_results_due[$];

  // Apply one bus access to the mapper state and work out its result word
  task automatic model_access(input logic [KindW-1:0] kind, input logic [AddrW-1:0] addr,
                              input logic [ByteW-1:0] value, output access_result_t res);
    clk_regs_t        clk_seen;
    logic [ByteW-1:0] sel_byte;
    logic [ByteW-1:0] reduced;
    res      = '0;
    clk_seen = latched_q ? held_clk : live_clk;
    case (kind)
      KIND_CTRL: begin
        case (addr[AddrW-1:AddrW-2])
          REG_ENABLE: begin
            if (value[3:0] == ENABLE_NIBBLE[3:0]) enabled_q = 1'b1;
            else if (value == '0) enabled_q = 1'b0;
          end
          REG_ROMBANK: begin
            rom_bank_q = (value[RomBankW-1:0] == '0) ? RomBankW'(1) : value[RomBankW-1:0];
          end
          REG_SELECT: begin
            if (enabled_q) begin
              if (value >= CLK_SEL_LO && value <= CLK_SEL_HI) begin
                // register 0x8 maps to the seconds code, and on up
                sel_byte    = value - (CLK_SEL_LO - ByteW'(SEL_SEC));
                clock_sel_q = sel_byte[SelW-1:0];
              end else begin
                clock_sel_q = SEL_NONE;
                ram_bank_q  = value[RamBankW-1:0];
              end
            end
          end
          default: begin
            // latch edge: a one straight after a zero
            if (last_latch_byte_q == '0 && value == 8'd1) begin
              held_clk  = live_clk;
              latched_q = ~latched_q;
            end
            last_latch_byte_q = value;
          end
        endcase
      end
      KIND_RD: begin
        if (clock_sel_q == SEL_NONE) begin
          res.to_ram = 1'b1;
        end else begin
          clock_hits_o++;
          case (clock_sel_q)
            SEL_SEC:   res.read_byte = ByteW'(clk_seen.sec);
            SEL_MIN:   res.read_byte = ByteW'(clk_seen.min);
            SEL_HOUR:  res.read_byte = ByteW'(clk_seen.hour);
            SEL_DAYLO: res.read_byte = clk_seen.day[7:0];
            default:   res.read_byte = clk_seen.day[15:8];
          endcase
        end
      end
      KIND_WR: begin
        if (clock_sel_q == SEL_NONE) begin
          res.to_ram = 1'b1;
        end else begin
          clock_hits_o++;
          case (clock_sel_q)
            SEL_SEC: begin
              reduced      = value % 8'd60;
              clk_seen.sec = reduced[SecW-1:0];
            end
            SEL_MIN: begin
              reduced      = value % 8'd60;
              clk_seen.min = reduced[SecW-1:0];
            end
            SEL_HOUR: begin
              reduced       = value % 8'd24;
              clk_seen.hour = reduced[HourW-1:0];
            end
            SEL_DAYLO: clk_seen.day[7:0] = value;
            default:   clk_seen.day[15:8] = (value & DAYHI_MASK) | DAYHI_FILL;
          endcase
          if (latched_q) held_clk = clk_seen;
          else live_clk = clk_seen;
        end
      end
      default: ;
    endcase
    res.ram_bank = ram_bank_q;
    res.rom_bank = rom_bank_q;
    res.enabled  = enabled_q;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t want;
    if (!rst_ni) begin
      enabled_q         = 1'b0;
      rom_bank_q        = RomBankW'(1);
      ram_bank_q        = '0;
      clock_sel_q       = SEL_NONE;
      last_latch_byte_q = 8'hFF;
      latched_q         = 1'b0;
      live_clk          = '0;
      held_clk          = '0;
      mapper_results_due.delete();
      fail_count_o      = 0;
      pending_o         = 0;
      checked_o         = 0;
      clock_hits_o      = 0;
    end else begin
      // compare before predicting, so a word never meets its own access
      if (m_tvalid_i && m_tready_i) begin
        if (mapper_results_due.size() == 0) begin
          $error("result word 0x%0h arrived with no access outstanding", m_tdata_i);
          fail_count_o++;
        end else begin
          want = mapper_results_due.pop_front();
          check_field("read_data", 32'(want.read_byte), 32'(m_tdata_i[7:0]));
          check_field("forward_to_ram", 32'(want.to_ram), 32'(m_tuser_i));
          check_field("ram_bank", 32'(want.ram_bank), 32'(m_tdata_i[9:8]));
          check_field("rom_bank", 32'(want.rom_bank), 32'(m_tdata_i[16:10]));
          check_field("ram_enabled", 32'(want.enabled), 32'(m_tdata_i[17]));
          checked_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        model_access(s_tuser_i, s_tdata_i[AddrW-1:0], s_tdata_i[AddrW+ByteW-1:AddrW], want);
        mapper_results_due.push_back(want);
      end
      pending_o = mapper_results_due.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Top of the bench for the cartridge bank mapper with clock registers.
// Drives bus accesses and receiver stalls; bmcr_access_checker does the checking.
// Depends on bmcr_pkg, bank_mapper_with_clock_registers_top and bmcr_access_checker.
`timescale 1ns / 1ps

module tb_top;

  import bmcr_pkg::*;

  localparam int unsigned DirectedCount  = 25;
  localparam int unsigned RandomAccesses = 850;
  localparam int unsigned DrainCycles    = 10;
  localparam int unsigned CycleLimit     = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [KindW-1:0]    s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned clock_hits;
  int unsigned accesses_sent;
  int unsigned cycle_count = 0;
  // while set, neither side inserts gaps: back-to-back stretches
  logic        quiet_phase;

  bank_mapper_with_clock_registers_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  bmcr_access_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tuser_i    (s_axis_tuser_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tuser_i    (m_axis_tuser_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .clock_hits_o (clock_hits)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Hard stop: far beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Run stopped after %0d cycles with %0d words outstanding", cycle_count, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Present one word at a falling edge and hold it until the handshake
  task automatic send_access(input logic [KindW-1:0] kind, input logic [AddrW-1:0] addr,
                             input logic [ByteW-1:0] value);
    int unsigned gap;
    gap = idle_cycles();
    @(negedge clk_i);
    if (gap != 0) begin
      // drop valid and scramble the bus while idle
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= InDataW'($urandom);
      s_axis_tuser_i  <= KindW'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, value, addr};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    accesses_sent++;
  endtask

  // Control write to a region, random offset inside it
  task automatic send_ctrl(input logic [1:0] region, input logic [ByteW-1:0] value);
    logic [AddrW-3:0] offset;
    offset = (AddrW-2)'($urandom);
    send_access(KIND_CTRL, {region, offset}, value);
  endtask

  // Select byte that never names a clock register
  function automatic logic [ByteW-1:0] ram_select_byte();
    logic [ByteW-1:0] v;
    v = ByteW'($urandom);
    if (v >= CLK_SEL_LO && v <= CLK_SEL_HI) v = v ^ CLK_SEL_LO;
    return v;
  endfunction

  // Receiver: runs of ready broken by stalls of random length
  initial begin
    int unsigned run_len;
    int unsigned stall_len;
    m_axis_tready_i = 1'b0;
    forever begin
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
      stall_len = idle_cycles();
      repeat (stall_len) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [3:0]  nib;
    int unsigned burst;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_CTRL;
    rst_ni          = 1'b0;
    quiet_phase     = 1'b0;
    accesses_sent   = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values, disabled select, enable quirks, ROM bank zero,
    // clock modulo and day-high mask, latch and unlatch, unused kind.
    send_access(KIND_RD, 15'h7FFF, 8'hFF);
    send_access(KIND_WR, 15'h0000, 8'hFF);
    send_access(KIND_CTRL, 15'h4000, CLK_SEL_LO);   // ignored: RAM still disabled
    send_access(KIND_CTRL, 15'h0000, 8'h1A);        // enable on low nibble alone
    send_access(KIND_CTRL, 15'h1FFF, 8'h55);        // neither enable nor disable
    send_access(KIND_CTRL, 15'h2000, 8'h00);        // bank 0 becomes 1
    send_access(KIND_CTRL, 15'h3FFF, 8'hFF);
    send_access(KIND_CTRL, 15'h2000, 8'h80);        // masks down to 0, so 1 again
    send_access(KIND_CTRL, 15'h5FFF, 8'hFF);        // RAM bank 3
    send_access(KIND_CTRL, 15'h4000, CLK_SEL_LO);   // seconds
    send_access(KIND_WR, 15'h0000, 8'hFF);
    send_access(KIND_CTRL, 15'h4000, 8'h0A);        // hours
    send_access(KIND_WR, 15'h0000, 8'hFF);
    send_access(KIND_CTRL, 15'h4000, CLK_SEL_HI);   // day high
    send_access(KIND_WR, 15'h0000, 8'h00);
    send_access(KIND_CTRL, 15'h6000, 8'h00);
    send_access(KIND_CTRL, 15'h7FFF, 8'h01);        // latch the live clock
    send_access(KIND_WR, 15'h0000, 8'hFF);          // lands in the held copy
    send_access(KIND_RD, 15'h0000, 8'h00);
    send_access(KIND_CTRL, 15'h6000, 8'h00);
    send_access(KIND_CTRL, 15'h6000, 8'h01);        // unlatch
    send_access(KIND_RD, 15'h7FFF, 8'hFF);
    send_access(KIND_UNUSED, 15'h7FFF, 8'hFF);
    send_access(KIND_CTRL, 15'h0000, 8'h00);        // disable
    send_access(KIND_RD, 15'h0000, 8'h00);          // clock reads ignore the enable

    // Random: mostly well-formed clock sessions and bank moves, some noise
    while (accesses_sent < DirectedCount + RandomAccesses) begin
      quiet_phase = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          nib = 4'($urandom);
          send_ctrl(REG_ENABLE, {nib, ENABLE_NIBBLE[3:0]});
          send_ctrl(REG_SELECT, ByteW'($urandom_range(CLK_SEL_LO, CLK_SEL_HI)));
          burst = $urandom_range(2, 8);
          repeat (burst) send_access(KindW'($urandom_range(KIND_RD, KIND_WR)),
                                     AddrW'($urandom), ByteW'($urandom));
          if ($urandom_range(0, 2) == 0) begin
            send_ctrl(REG_LATCH, 8'h00);
            send_ctrl(REG_LATCH, 8'h01);
            burst = $urandom_range(1, 6);
            repeat (burst) send_access(KindW'($urandom_range(KIND_RD, KIND_WR)),
                                       AddrW'($urandom), ByteW'($urandom));
          end
          if ($urandom_range(0, 1) == 0) send_ctrl(REG_SELECT, ram_select_byte());
        end
        3: begin
          // latch pair, sometimes broken by a stray byte
          send_ctrl(REG_LATCH, 8'h00);
          if ($urandom_range(0, 3) == 0) send_ctrl(REG_LATCH, ByteW'($urandom));
          send_ctrl(REG_LATCH, 8'h01);
        end
        4: begin
          if ($urandom_range(0, 3) == 0) send_ctrl(REG_ROMBANK, {$urandom_range(0, 1) == 1, 7'd0});
          else send_ctrl(REG_ROMBANK, ByteW'($urandom));
          send_ctrl(REG_SELECT, ram_select_byte());
        end
        5, 6: begin
          burst = $urandom_range(1, 6);
          repeat (burst) send_access(KindW'($urandom_range(KIND_RD, KIND_WR)),
                                     AddrW'($urandom), ByteW'($urandom));
        end
        7: begin
          case ($urandom_range(0, 2))
            0:       send_ctrl(REG_ENABLE, 8'h00);
            1:       send_ctrl(REG_ENABLE, ByteW'($urandom));
            default: begin
              nib = 4'($urandom);
              send_ctrl(REG_ENABLE, {nib, ENABLE_NIBBLE[3:0]});
            end
          endcase
        end
        default: begin
          burst = $urandom_range(1, 6);
          repeat (burst) send_access(KindW'($urandom_range(KIND_CTRL, KIND_UNUSED)),
                                     AddrW'($urandom), ByteW'($urandom));
        end
      endcase
    end
    quiet_phase = 1'b0;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    // Wait for every outstanding word, then give the pipeline time to misbehave
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Drove %0d bus accesses (%0d directed) with gaps and stalls on both channels;",
             accesses_sent, DirectedCount);
    $display("checked %0d result words, %0d of them clock-register accesses.",
             checked, clock_hits);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
